### rtl/dvu_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the distance vector update block
package dvu_pkg;

	localparam int NODE_COUNT = 4;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int COST_W = 10;
	localparam int LINK_COUNT = 3;
	localparam int CFG_INDEX_W = 2;

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [NODE_W-1:0] node_t;
	typedef logic [NODE_COUNT-1:0][COST_W-1:0] row_t;

	localparam cost_t INFINITY_COST = COST_W'(999);
	localparam cost_t SELF_COST = '0;
	localparam cost_t LINK_COST_1_RESET = COST_W'(1);
	localparam cost_t LINK_COST_2_RESET = COST_W'(3);
	localparam cost_t LINK_COST_3_RESET = COST_W'(7);

	typedef enum logic {
		FUNC_INIT   = 1'b0,
		FUNC_UPDATE = 1'b1
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINK_COST_1 = 2'd0,
		REG_LINK_COST_2 = 2'd1,
		REG_LINK_COST_3 = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic  init;
		logic  update;
		node_t src;
		cost_t base;
	} lane_cmd_t;

	typedef struct packed {
		cost_t min;
		logic  dropped;
	} lane_res_t;

	typedef lane_res_t [NODE_COUNT-1:0] lane_res_vec_t;

	function automatic cost_t row_min(input row_t row);
		cost_t m;
		m = row[0];
		for (int v = 1; v < NODE_COUNT; v++) begin
			if (row[v] < m) begin
				m = row[v];
			end
		end
		return m;
	endfunction

endpackage

### rtl/dvu_if.sv
`timescale 1ns / 1ps
// channel interfaces: update requests, result vectors and register writes
interface dvu_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [1:0]  src;
	logic [9:0]  adv_cost_0;
	logic [9:0]  adv_cost_1;
	logic [9:0]  adv_cost_2;
	logic [9:0]  adv_cost_3;

	modport source (
		output valid, func, src, adv_cost_0, adv_cost_1, adv_cost_2, adv_cost_3,
		input  ready
	);
	modport sink (
		input  valid, func, src, adv_cost_0, adv_cost_1, adv_cost_2, adv_cost_3,
		output ready
	);
endinterface

interface dvu_rsp_if;
	logic        valid;
	logic        ready;
	logic [9:0]  best_cost_0;
	logic [9:0]  best_cost_1;
	logic [9:0]  best_cost_2;
	logic [9:0]  best_cost_3;

	modport source (
		output valid, best_cost_0, best_cost_1, best_cost_2, best_cost_3,
		input  ready
	);
	modport sink (
		input  valid, best_cost_0, best_cost_1, best_cost_2, best_cost_3,
		output ready
	);
endinterface

interface dvu_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [9:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

### rtl/distance_vector_update.sv
`timescale 1ns / 1ps
// distance vector update for node 0: top level
// Takes one request per clock while the result register is free. An init
// request (func 0) rebuilds the 4x4 route table from the link cost registers
// and always returns the best cost vector. An update request (func 1) relaxes
// the column of neighbour src with best_cost[src] + adv_cost_d in four
// destination lanes at once, recomputes the row minima and returns the vector
// in the next cycle only if some minimum dropped. Each request is finished in
// the cycle it transfers: the lane add, compare and four-way minimum set the
// clock, and the single result register sets the rate to one request per
// cycle when the result side keeps up. Link cost writes are taken every
// cycle; writes to an index past the third register are ignored.
module distance_vector_update import dvu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dvu_req_if.sink    req,
	dvu_rsp_if.source  rsp,
	dvu_cfg_if.sink    cfg
);

	cost_t          link_cost_q [LINK_COUNT];
	cost_t          direct [NODE_COUNT];
	cost_t          adv [NODE_COUNT];
	row_t           lane_best;
	lane_res_vec_t  lane_res;
	lane_cmd_t      cmd;
	logic           free;
	logic           accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_cost_q[0] <= LINK_COST_1_RESET;
			link_cost_q[1] <= LINK_COST_2_RESET;
			link_cost_q[2] <= LINK_COST_3_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINK_COST_1: link_cost_q[0] <= cfg.data;
				REG_LINK_COST_2: link_cost_q[1] <= cfg.data;
				REG_LINK_COST_3: link_cost_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign direct[0] = SELF_COST;
	assign direct[1] = link_cost_q[0];
	assign direct[2] = link_cost_q[1];
	assign direct[3] = link_cost_q[2];

	assign adv[0] = req.adv_cost_0;
	assign adv[1] = req.adv_cost_1;
	assign adv[2] = req.adv_cost_2;
	assign adv[3] = req.adv_cost_3;

	assign req.ready = free;
	assign accept = req.valid && free;

	always_comb begin
		cmd.init = accept && req.func == FUNC_INIT;
		cmd.update = accept && req.func == FUNC_UPDATE;
		cmd.src = req.src;
		cmd.base = lane_best[req.src];
	end

	for (genvar d = 0; d < NODE_COUNT; d++) begin : g_lane
		dvu_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.lane_id (NODE_W'(d)),
			.cmd     (cmd),
			.adv     (adv[d]),
			.direct  (direct[d]),
			.best    (lane_best[d]),
			.res     (lane_res[d])
		);
	end

	dvu_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (lane_res),
		.free   (free),
		.rsp    (rsp)
	);

endmodule

### rtl/dvu_lane.sv
`timescale 1ns / 1ps
// one destination row of the route table with its relaxation and row minimum
module dvu_lane import dvu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  node_t     lane_id,
	input  lane_cmd_t cmd,
	input  cost_t     adv,
	input  cost_t     direct,
	output cost_t     best,
	output lane_res_t res
);

	row_t              row_q;
	row_t              row_d;
	cost_t             best_q;
	cost_t             min_d;
	cost_t             cur_min;
	logic [COST_W:0]   sum;

	always_comb begin
		sum = {1'b0, cmd.base} + {1'b0, adv};
		row_d = row_q;
		for (int v = 0; v < NODE_COUNT; v++) begin
			if (cmd.init) begin
				row_d[v] = (NODE_W'(v) == lane_id) ? direct : INFINITY_COST;
			end else if (cmd.update && NODE_W'(v) == cmd.src && sum < {1'b0, row_q[v]}) begin
				row_d[v] = sum[COST_W-1:0];
			end
		end
		min_d = row_min(row_d);
		cur_min = row_min(row_q);
	end

	assign res.min = min_d;
	assign res.dropped = min_d < best_q;
	assign best = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= {NODE_COUNT{INFINITY_COST}};
			best_q <= INFINITY_COST;
		end else if (cmd.init || cmd.update) begin
			row_q <= row_d;
			best_q <= min_d;
		end
	end

	// best cost always tracks the stored row
	a_best_is_row_min: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> best_q == cur_min)
		else $error("best cost differs from row minimum");

	// an update can only lower the best cost
	a_update_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !cmd.init |=> best_q <= $past(best_q))
		else $error("best cost rose on update");

	// init loads the direct cost on the diagonal
	a_init_diag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> row_q[lane_id] == $past(direct))
		else $error("diagonal not loaded on init");

endmodule

### rtl/dvu_merge.sv
`timescale 1ns / 1ps
// merges lane results and holds the result vector until transfer
module dvu_merge import dvu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  lane_cmd_t      cmd,
	input  lane_res_vec_t  res,
	output logic           free,
	dvu_rsp_if.source      rsp
);

	logic   valid_q;
	logic   any_drop;
	logic   emit;
	row_t   vec_q;

	always_comb begin
		any_drop = 1'b0;
		for (int k = 0; k < NODE_COUNT; k++) begin
			any_drop = any_drop | res[k].dropped;
		end
		emit = cmd.init || (cmd.update && any_drop);
	end

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int k = 0; k < NODE_COUNT; k++) begin
				vec_q[k] <= res[k].min;
			end
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.best_cost_0 = vec_q[0];
	assign rsp.best_cost_1 = vec_q[1];
	assign rsp.best_cost_2 = vec_q[2];
	assign rsp.best_cost_3 = vec_q[3];

	// no new result while the held one waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> free)
		else $error("result overwritten before transfer");

	// init always produces a result
	a_init_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init |=> valid_q)
		else $error("init gave no result");

	// update without any drop gives nothing new
	a_quiet_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !cmd.init && !any_drop && !valid_q |=> !valid_q)
		else $error("result without a drop");

endmodule
